/* rtl/core/framebuffer_text_plotter_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the frame buffer text plotter.
// Assertions sampled on the rising edge of i_clk in the scope that uses them.
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_TEXT_PLOTTER_TOP_DEFINES_SVH
`define FRAMEBUFFER_TEXT_PLOTTER_TOP_DEFINES_SVH

// Checked only while the block is out of reset.
`define FBTP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define FBTP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/core/fbtp_pkg.sv */
// ----------------------------------------------------------------------------
// fbtp_pkg
// Shared constants and item types of the frame buffer text plotter.
// ----------------------------------------------------------------------------
`default_nettype none

package fbtp_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int FONT_ROWS     = 2048;
    localparam int FIRST_GLYPH   = 32;
    localparam int PAGE_BITS     = 8;
    localparam int GLYPH_MAX     = 16;
    localparam int FRAME_BYTES   = SCREEN_WIDTH * SCREEN_HEIGHT / PAGE_BITS;
    localparam int FB_AW         = $clog2(FRAME_BYTES);
    localparam int FONT_AW       = $clog2(FONT_ROWS);
    localparam int ROW_W         = $clog2((256 - FIRST_GLYPH) * GLYPH_MAX);
    localparam int CFG_W         = 5;
    localparam int CFG_NUM       = 2;
    localparam int CFG_IDX_W     = $clog2(CFG_NUM);

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_PIXEL  = 3'd1;
    localparam logic [2:0] CMD_CURSOR = 3'd2;
    localparam logic [2:0] CMD_CHAR   = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;
    localparam logic [2:0] CMD_FONT   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic        paint_color;
        logic [7:0]  char_code;
        logic [10:0] font_address;
        logic [15:0] font_row_bits;
        logic [9:0]  byte_address;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] cursor_x_now;
        logic [7:0] cursor_y_now;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/framebuffer_text_plotter_top.sv */
// ----------------------------------------------------------------------------
// framebuffer_text_plotter_top
// Page-organized monochrome frame buffer with pixel, cursor and glyph drawing.
// ----------------------------------------------------------------------------
// Set cursor, font load, off-screen draw pixel, control characters and unused commands
// finish from ST_IDLE; on-screen draw pixel and read byte end in ST_PIX_WR or ST_READ;
// clear zeroes each byte in ST_CLEAR; a glyph runs ST_ROW, ST_BITS, ST_GPIX and ST_GWR.
// One item at a time: busy falls in the cycle that shows the result strobe, and a new
// item can be accepted at the end of that cycle. After reset the block is busy while
// the frame memory is zeroed, one byte per cycle; results cannot stall.
`default_nettype none

module framebuffer_text_plotter_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  fbtp_pkg::t_item               i_item,
    output logic                          o_valid,
    output fbtp_pkg::t_result             o_result,
    input  wire                           i_cfg_we,
    input  wire [fbtp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [fbtp_pkg::CFG_W-1:0]     i_cfg_data
);
    import fbtp_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_INIT   = 9'b000000010,
        ST_CLEAR  = 9'b000000100,
        ST_PIX_WR = 9'b000001000,
        ST_READ   = 9'b000010000,
        ST_ROW    = 9'b000100000,
        ST_BITS   = 9'b001000000,
        ST_GPIX   = 9'b010000000,
        ST_GWR    = 9'b100000000
    } t_state;

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > CFG_W'(GLYPH_MAX)) begin
            r = CFG_W'(GLYPH_MAX);
        end
        return r;
    endfunction

    function automatic logic on_screen(input logic [7:0] x, input logic [7:0] y);
        return (32'(x) < SCREEN_WIDTH) && (32'(y) < SCREEN_HEIGHT);
    endfunction

    function automatic logic [FB_AW-1:0] pix_index(input logic [7:0] x,
                                                   input logic [7:0] y);
        return FB_AW'((32'(y) / PAGE_BITS) * SCREEN_WIDTH + 32'(x));
    endfunction

    logic [7:0] fb_mem [FRAME_BYTES];
    logic [15:0] font_mem [FONT_ROWS];

    t_state             r_state, n_state;
    logic [FB_AW-1:0]   r_clr, n_clr;
    logic [7:0]         r_cur_x, n_cur_x;
    logic [7:0]         r_cur_y, n_cur_y;
    logic [CFG_W-1:0]   r_gw, r_gh;
    logic [CFG_W-1:0]   r_w, n_w;
    logic [CFG_W-1:0]   r_h, n_h;
    logic [ROW_W-1:0]   r_base, n_base;
    logic [3:0]         r_i, n_i;
    logic [3:0]         r_j, n_j;
    logic               r_valid;
    logic               r_white, n_white;
    logic [15:0]        r_bits, n_bits;
    logic [FB_AW-1:0]   r_pix_addr, n_pix_addr;
    logic [7:0]         r_pix_mask, n_pix_mask;
    logic               r_pix_set, n_pix_set;
    t_result            r_result;
    logic [7:0]         r_fb_rdata;
    logic [15:0]        r_font_rdata;

    logic               fb_we;
    logic [FB_AW-1:0]   fb_waddr, fb_raddr;
    logic [7:0]         fb_wdata, wr_byte;
    logic               font_we;
    logic [FONT_AW-1:0] font_waddr, font_raddr;
    logic               finish, adv_col, adv_row, row_last, col_last;
    logic [7:0]         res_rd, gx, gy;
    logic [ROW_W-1:0]   row_idx;
    logic [CFG_W-1:0]   eff_w, eff_h;

    assign eff_w    = clamp_size(r_gw);
    assign eff_h    = clamp_size(r_gh);
    assign row_idx  = r_base + ROW_W'(r_i);
    assign gx       = r_cur_x + 8'(r_j);
    assign gy       = r_cur_y + 8'(r_i);
    assign row_last = (r_i == 4'(r_h - CFG_W'(1)));
    assign col_last = (r_j == 4'(r_w - CFG_W'(1)));
    assign wr_byte  = r_pix_set ? (r_fb_rdata | r_pix_mask) : (r_fb_rdata & ~r_pix_mask);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_w        = r_w;
        n_h        = r_h;
        n_base     = r_base;
        n_i        = r_i;
        n_j        = r_j;
        n_white    = r_white;
        n_bits     = r_bits;
        n_pix_addr = r_pix_addr;
        n_pix_mask = r_pix_mask;
        n_pix_set  = r_pix_set;
        fb_we      = 1'b0;
        fb_waddr   = r_pix_addr;
        fb_wdata   = wr_byte;
        fb_raddr   = r_pix_addr;
        font_we    = 1'b0;
        font_waddr = FONT_AW'(i_item.font_address);
        font_raddr = FONT_AW'(row_idx);
        finish     = 1'b0;
        adv_col    = 1'b0;
        adv_row    = 1'b0;
        res_rd     = '0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_item.command)
                        CMD_CLEAR: begin
                            n_clr   = '0;
                            n_state = ST_CLEAR;
                        end
                        CMD_PIXEL: begin
                            if (on_screen(i_item.pixel_x, i_item.pixel_y)) begin
                                fb_raddr   = pix_index(i_item.pixel_x, i_item.pixel_y);
                                n_pix_addr = pix_index(i_item.pixel_x, i_item.pixel_y);
                                n_pix_mask = 8'(1) << i_item.pixel_y[2:0];
                                n_pix_set  = i_item.paint_color;
                                n_state    = ST_PIX_WR;
                            end else begin
                                finish = 1'b1;
                            end
                        end
                        CMD_CURSOR: begin
                            n_cur_x = i_item.pixel_x;
                            n_cur_y = i_item.pixel_y;
                            finish  = 1'b1;
                        end
                        CMD_CHAR: begin
                            if (32'(i_item.char_code) < FIRST_GLYPH) begin
                                finish = 1'b1;
                            end else begin
                                n_w     = eff_w;
                                n_h     = eff_h;
                                n_white = i_item.paint_color;
                                n_base  = ROW_W'(32'(i_item.char_code) - FIRST_GLYPH)
                                          * ROW_W'(eff_h);
                                n_i     = '0;
                                n_state = ST_ROW;
                            end
                        end
                        CMD_READ: begin
                            fb_raddr = FB_AW'(i_item.byte_address);
                            if (32'(i_item.byte_address) < FRAME_BYTES) begin
                                n_state = ST_READ;
                            end else begin
                                finish = 1'b1;
                            end
                        end
                        CMD_FONT: begin
                            font_we = (32'(i_item.font_address) < FONT_ROWS);
                            finish  = 1'b1;
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_INIT, ST_CLEAR: begin
                fb_we    = 1'b1;
                fb_waddr = r_clr;
                fb_wdata = '0;
                if (r_clr == FB_AW'(FRAME_BYTES - 1)) begin
                    finish  = (r_state == ST_CLEAR);
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + FB_AW'(1);
                end
            end
            ST_PIX_WR: begin
                fb_we   = 1'b1;
                finish  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_READ: begin
                res_rd  = r_fb_rdata;
                finish  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_ROW: begin
                if (32'(row_idx) < FONT_ROWS) begin
                    n_state = ST_BITS;
                end else begin
                    adv_row = 1'b1;
                end
            end
            ST_BITS: begin
                n_bits  = r_font_rdata;
                n_j     = '0;
                n_state = ST_GPIX;
            end
            ST_GPIX: begin
                if (on_screen(gx, gy)) begin
                    fb_raddr   = pix_index(gx, gy);
                    n_pix_addr = pix_index(gx, gy);
                    n_pix_mask = 8'(1) << gy[2:0];
                    n_pix_set  = r_bits[r_j] ? r_white : ~r_white;
                    n_state    = ST_GWR;
                end else begin
                    adv_col = 1'b1;
                end
            end
            ST_GWR: begin
                fb_we   = 1'b1;
                adv_col = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (adv_col) begin
            if (col_last) begin
                adv_row = 1'b1;
            end else begin
                n_j     = r_j + 4'd1;
                n_state = ST_GPIX;
            end
        end
        if (adv_row) begin
            if (row_last) begin
                n_cur_x = r_cur_x + 8'(r_w);
                finish  = 1'b1;
                n_state = ST_IDLE;
            end else begin
                n_i     = r_i + 4'd1;
                n_state = ST_ROW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            fb_mem[fb_waddr] <= fb_wdata;
        end
        r_fb_rdata <= fb_mem[fb_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (font_we) begin
            font_mem[font_waddr] <= i_item.font_row_bits;
        end
        r_font_rdata <= font_mem[font_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_clr   <= '0;
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_gw    <= CFG_W'(8);
            r_gh    <= CFG_W'(16);
            r_w     <= CFG_W'(1);
            r_h     <= CFG_W'(1);
            r_base  <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_w     <= n_w;
            r_h     <= n_h;
            r_base  <= n_base;
            r_i     <= n_i;
            r_j     <= n_j;
            r_valid <= finish;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GLYPH_WIDTH:  r_gw <= i_cfg_data;
                    CFG_GLYPH_HEIGHT: r_gh <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_white    <= n_white;
        r_bits     <= n_bits;
        r_pix_addr <= n_pix_addr;
        r_pix_mask <= n_pix_mask;
        r_pix_set  <= n_pix_set;
        if (finish) begin
            r_result.read_data    <= res_rd;
            r_result.cursor_x_now <= n_cur_x;
            r_result.cursor_y_now <= n_cur_y;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

/* rtl/core/fbtp_checker.sv */
// ----------------------------------------------------------------------------
// fbtp_checker
// Port-level assertions for the frame buffer text plotter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "framebuffer_text_plotter_top_defines.svh"

module fbtp_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               start,
    input wire               busy,
    input fbtp_pkg::t_item   i_item,
    input wire               o_valid,
    input fbtp_pkg::t_result o_result
);
    import fbtp_pkg::*;

    `FBTP_ASSERT(a_result_when_idle, o_valid |-> !busy, "result shown while busy")

    `FBTP_ASSERT(a_cursor_echo, (start && !busy && i_item.command == CMD_CURSOR) |=> (o_valid && o_result.cursor_x_now == $past(i_item.pixel_x) && o_result.cursor_y_now == $past(i_item.pixel_y) && o_result.read_data == 8'd0), "set cursor result wrong")

    `FBTP_ASSERT(a_read_two_cycles, (start && !busy && i_item.command == CMD_READ) |=> (busy && !o_valid) ##1 (o_valid && !busy), "read byte timing wrong")

    `FBTP_ASSERT_ALWAYS(a_reset_sweep, !i_rst_n |=> (busy && !o_valid), "not clearing after reset")

endmodule

bind framebuffer_text_plotter_top fbtp_checker u_fbtp_checker (.*);

`default_nettype wire
